// ===== hdl/pct_pkg.sv =====
// shared types, codes and widths of the priority thread picker
package pct_pkg;

  localparam int OPC_W      = 2;
  localparam int TID_W      = 4;
  localparam int STS_W      = 2;
  localparam int POS_W      = 4;
  localparam int KIND_W     = 3;
  localparam int STEP_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PCT_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT = 1'd1;

  typedef enum logic [OPC_W-1:0] {
    OP_ADD    = 2'd0,
    OP_SET    = 2'd1,
    OP_SELECT = 2'd2
  } opcode_e;

  typedef enum logic [STS_W-1:0] {
    ST_DISABLED = 2'd0,
    ST_ENABLED  = 2'd1,
    ST_SLEEPING = 2'd2
  } status_e;

  typedef enum logic [KIND_W-1:0] {
    K_ACK      = 3'd0,
    K_PICK     = 3'd1,
    K_FALLBACK = 3'd2,
    K_WAKE     = 3'd3,
    K_NONE     = 3'd4,
    K_FULL     = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD_CHK,
    S_ADD_SHIFT,
    S_ADD_MOVE,
    S_SET_WR,
    S_WALK,
    S_WALK_ST,
    S_WALK_CHK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic  capture;
    logic  stat_rd_tid;
    logic  stat_rd_entry;
    logic  stat_wr;
    logic  idx_load_cnt;
    logic  idx_clear;
    logic  idx_dec;
    logic  idx_inc;
    logic  plist_rd_prev;
    logic  plist_rd_idx;
    logic  plist_wr_move;
    logic  plist_wr_ins;
    logic  step_upd;
    logic  res_set;
    kind_e res_kind;
    logic  res_pick_entry;
    logic  out_load;
  } pct_cmd_t;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic             tid_ok;
    logic             st_ok;
    logic             list_full;
    logic             any_en;
    logic             any_sl;
    logic             pick_ok;
    logic             idx_gt_pos;
    logic             idx_lt_cnt;
    logic             entry_en;
    logic             out_free;
  } pct_sts_t;

endpackage

// ===== hdl/pct_if.sv =====
// request and result channel interfaces of the priority thread picker
interface pct_req_if;
  import pct_pkg::*;
  logic               valid;
  logic               ready;
  logic [OPC_W-1:0]   opcode;
  logic [TID_W-1:0]   thread_id;
  logic [STS_W-1:0]   status;
  logic [POS_W-1:0]   insert_pos;
  modport source (output valid, output opcode, output thread_id, output status,
                  output insert_pos, input ready);
  modport sink (input valid, input opcode, input thread_id, input status,
                input insert_pos, output ready);
endinterface

interface pct_res_if;
  import pct_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TID_W-1:0]  picked_id;
  logic              livelock;
  modport source (output valid, output kind, output picked_id, output livelock,
                  input ready);
  modport sink (input valid, input kind, input picked_id, input livelock,
                output ready);
endinterface

// ===== hdl/pct_priority_thread_picker.sv =====
// top level of the priority thread picker
// One request is worked at a time; its result sits in an output register, and
// the next request is taken while that result waits. A request answered at once
// (a select without a pick, a full list, an unused code or thread) goes from
// dispatch straight to its result; a set-status reads and then writes the
// status memory; an add writes the status, moves each list entry behind its
// place down by reading it and writing it one slot on, then inserts; a priority
// pick reads each list entry in turn and then that entry's status, and stops at
// the first enabled one or at the end of the list. A result that waits in the
// output register holds the next one in its last state for as long as it
// waits. Enabled and sleeping threads are kept in counters, so no status scan
// is needed. Reset is immediate: there is no clearing pass.
module pct_priority_thread_picker #(
  parameter int MAX_THREADS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pct_req_if.sink                        req_i,
  pct_res_if.source                      rsp_o,
  input  logic                           cfg_we_i,
  input  logic [pct_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pct_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pct_pkg::*;

  pct_cmd_t cmd;
  pct_sts_t sts;

  pct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pct_dpath #(
    .MAX_THREADS (MAX_THREADS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_opcode_i     (req_i.opcode),
    .req_thread_id_i  (req_i.thread_id),
    .req_status_i     (req_i.status),
    .req_insert_pos_i (req_i.insert_pos),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .res_valid_o      (rsp_o.valid),
    .res_ready_i      (rsp_o.ready),
    .res_kind_o       (rsp_o.kind),
    .res_picked_id_o  (rsp_o.picked_id),
    .res_livelock_o   (rsp_o.livelock)
  );

endmodule

// ===== hdl/pct_ctrl.sv =====
// sequencing state machine of the priority thread picker
module pct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pct_pkg::pct_sts_t sts_i,
  output pct_pkg::pct_cmd_t cmd_o
);
  import pct_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (opcode_e'(sts_i.opcode))
          OP_ADD: begin
            if (!sts_i.tid_ok) begin
              cmd_o.res_set  = 1'b1;
              cmd_o.res_kind = K_ACK;
              state_d        = S_DONE;
            end else if (sts_i.list_full) begin
              cmd_o.res_set  = 1'b1;
              cmd_o.res_kind = K_FULL;
              state_d        = S_DONE;
            end else begin
              cmd_o.stat_rd_tid  = 1'b1;
              cmd_o.idx_load_cnt = 1'b1;
              state_d            = S_ADD_CHK;
            end
          end
          OP_SET: begin
            if (sts_i.tid_ok && sts_i.st_ok) begin
              cmd_o.stat_rd_tid = 1'b1;
              state_d           = S_SET_WR;
            end else begin
              cmd_o.res_set  = 1'b1;
              cmd_o.res_kind = K_ACK;
              state_d        = S_DONE;
            end
          end
          OP_SELECT: begin
            if (!sts_i.any_en) begin
              cmd_o.res_set  = 1'b1;
              cmd_o.res_kind = sts_i.any_sl ? K_WAKE : K_NONE;
              state_d        = S_DONE;
            end else if (!sts_i.pick_ok) begin
              cmd_o.step_upd = 1'b1;
              cmd_o.res_set  = 1'b1;
              cmd_o.res_kind = K_FALLBACK;
              state_d        = S_DONE;
            end else begin
              cmd_o.step_upd  = 1'b1;
              cmd_o.idx_clear = 1'b1;
              state_d         = S_WALK;
            end
          end
          default: begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_kind = K_ACK;
            state_d        = S_DONE;
          end
        endcase
      end
      S_ADD_CHK: begin
        cmd_o.stat_wr = 1'b1;
        state_d       = S_ADD_SHIFT;
      end
      S_ADD_SHIFT: begin
        if (sts_i.idx_gt_pos) begin
          cmd_o.plist_rd_prev = 1'b1;
          state_d             = S_ADD_MOVE;
        end else begin
          cmd_o.plist_wr_ins = 1'b1;
          cmd_o.res_set      = 1'b1;
          cmd_o.res_kind     = K_ACK;
          state_d            = S_DONE;
        end
      end
      S_ADD_MOVE: begin
        cmd_o.plist_wr_move = 1'b1;
        cmd_o.idx_dec       = 1'b1;
        state_d             = S_ADD_SHIFT;
      end
      S_SET_WR: begin
        cmd_o.stat_wr  = 1'b1;
        cmd_o.res_set  = 1'b1;
        cmd_o.res_kind = K_ACK;
        state_d        = S_DONE;
      end
      S_WALK: begin
        if (sts_i.idx_lt_cnt) begin
          cmd_o.plist_rd_idx = 1'b1;
          state_d            = S_WALK_ST;
        end else begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_kind = K_PICK;
          state_d        = S_DONE;
        end
      end
      S_WALK_ST: begin
        cmd_o.stat_rd_entry = 1'b1;
        state_d             = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (sts_i.entry_en) begin
          cmd_o.res_set        = 1'b1;
          cmd_o.res_kind       = K_PICK;
          cmd_o.res_pick_entry = 1'b1;
          state_d              = S_DONE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_WALK;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/pct_dpath.sv =====
// tables, counters, configuration and result registers of the thread picker
module pct_dpath #(
  parameter int MAX_THREADS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pct_pkg::pct_cmd_t              cmd_i,
  output pct_pkg::pct_sts_t              sts_o,
  input  logic [pct_pkg::OPC_W-1:0]      req_opcode_i,
  input  logic [pct_pkg::TID_W-1:0]      req_thread_id_i,
  input  logic [pct_pkg::STS_W-1:0]      req_status_i,
  input  logic [pct_pkg::POS_W-1:0]      req_insert_pos_i,
  input  logic                           cfg_we_i,
  input  logic [pct_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pct_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output logic [pct_pkg::KIND_W-1:0]     res_kind_o,
  output logic [pct_pkg::TID_W-1:0]      res_picked_id_o,
  output logic                           res_livelock_o
);
  import pct_pkg::*;

  localparam int IDX_W = (MAX_THREADS > 2) ? $clog2(MAX_THREADS) : 1;
  localparam int CNT_W = $clog2(MAX_THREADS + 1);

  logic [OPC_W-1:0]  op_q;
  logic [TID_W-1:0]  tid_q;
  logic [STS_W-1:0]  st_q;
  logic [POS_W-1:0]  pos_q;

  logic [TID_W-1:0]  plist_mem [MAX_THREADS];
  logic [TID_W-1:0]  plist_rdata_q;
  logic [STS_W-1:0]  stat_mem [MAX_THREADS];
  logic [STS_W-1:0]  stat_mem_rd_q;
  logic              stat_vld_q [MAX_THREADS];
  logic              stat_vld_rd_q;

  logic [CNT_W-1:0]  list_count_q;
  logic [CNT_W-1:0]  n_en_q;
  logic [CNT_W-1:0]  n_sl_q;
  logic [CNT_W-1:0]  idx_q;
  logic [STEP_W-1:0] step_count_q;
  logic [STEP_W-1:0] step_limit_q;
  logic              pct_en_q;
  logic              livelock_q;

  kind_e             res_kind_q;
  logic [TID_W-1:0]  res_pick_q;
  logic              out_valid_q;
  kind_e             out_kind_q;
  logic [TID_W-1:0]  out_pick_q;
  logic              out_live_q;

  logic [IDX_W-1:0]  tid_idx;
  logic [IDX_W-1:0]  stat_raddr;
  logic [IDX_W-1:0]  plist_raddr;
  logic [IDX_W-1:0]  plist_waddr;
  logic [TID_W-1:0]  plist_wdata;
  logic [CNT_W-1:0]  idx_m1;
  logic [CNT_W-1:0]  pos_eff;
  logic [STEP_W-1:0] step_inc;
  logic              over_limit;
  status_e           stat_old;
  status_e           stat_new;
  logic              old_en, old_sl, new_en, new_sl;

  assign tid_idx     = IDX_W'(tid_q);
  assign idx_m1      = idx_q - CNT_W'(1);
  assign pos_eff     = (32'(pos_q) > 32'(list_count_q)) ? list_count_q : CNT_W'(pos_q);
  assign step_inc    = (step_count_q == '1) ? step_count_q : step_count_q + STEP_W'(1);
  assign over_limit  = step_inc > step_limit_q;
  assign stat_old    = stat_vld_rd_q ? status_e'(stat_mem_rd_q) : ST_DISABLED;
  assign stat_new    = (op_q == OP_ADD) ? ST_ENABLED : status_e'(st_q);
  assign old_en      = stat_old == ST_ENABLED;
  assign old_sl      = stat_old == ST_SLEEPING;
  assign new_en      = stat_new == ST_ENABLED;
  assign new_sl      = stat_new == ST_SLEEPING;
  assign stat_raddr  = cmd_i.stat_rd_entry ? IDX_W'(plist_rdata_q) : tid_idx;
  assign plist_raddr = cmd_i.plist_rd_prev ? idx_m1[IDX_W-1:0] : idx_q[IDX_W-1:0];
  assign plist_waddr = cmd_i.plist_wr_ins ? pos_eff[IDX_W-1:0] : idx_q[IDX_W-1:0];
  assign plist_wdata = cmd_i.plist_wr_ins ? tid_q : plist_rdata_q;

  always_comb begin
    sts_o            = '0;
    sts_o.opcode     = op_q;
    sts_o.tid_ok     = 32'(tid_q) < MAX_THREADS;
    sts_o.st_ok      = (st_q == ST_DISABLED) || (st_q == ST_ENABLED) ||
                       (st_q == ST_SLEEPING);
    sts_o.list_full  = list_count_q == CNT_W'(MAX_THREADS);
    sts_o.any_en     = n_en_q != '0;
    sts_o.any_sl     = n_sl_q != '0;
    sts_o.pick_ok    = pct_en_q && !over_limit;
    sts_o.idx_gt_pos = idx_q > pos_eff;
    sts_o.idx_lt_cnt = idx_q < list_count_q;
    sts_o.entry_en   = old_en;
    sts_o.out_free   = !out_valid_q || res_ready_i;
  end

  // captured request
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= req_opcode_i;
      tid_q <= req_thread_id_i;
      st_q  <= req_status_i;
      pos_q <= req_insert_pos_i;
    end
  end

  // priority list memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.plist_wr_ins || cmd_i.plist_wr_move) begin
      plist_mem[plist_waddr] <= plist_wdata;
    end
    if (cmd_i.plist_rd_prev || cmd_i.plist_rd_idx) begin
      plist_rdata_q <= plist_mem[plist_raddr];
    end
  end

  // status memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.stat_wr) begin
      stat_mem[tid_idx] <= stat_new;
    end
    if (cmd_i.stat_rd_tid || cmd_i.stat_rd_entry) begin
      stat_mem_rd_q <= stat_mem[stat_raddr];
      stat_vld_rd_q <= stat_vld_q[stat_raddr];
    end
  end

  // unwritten status entries read as disabled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_THREADS; i++) begin
        stat_vld_q[i] <= 1'b0;
      end
    end else if (cmd_i.stat_wr) begin
      stat_vld_q[tid_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_count_q <= '0;
      n_en_q       <= '0;
      n_sl_q       <= '0;
      idx_q        <= '0;
      step_count_q <= '0;
      step_limit_q <= '1;
      pct_en_q     <= 1'b1;
      livelock_q   <= 1'b0;
    end else begin
      if (cmd_i.plist_wr_ins) begin
        list_count_q <= list_count_q + CNT_W'(1);
      end
      if (cmd_i.stat_wr) begin
        if (old_en && !new_en) begin
          n_en_q <= n_en_q - CNT_W'(1);
        end else if (!old_en && new_en) begin
          n_en_q <= n_en_q + CNT_W'(1);
        end
        if (old_sl && !new_sl) begin
          n_sl_q <= n_sl_q - CNT_W'(1);
        end else if (!old_sl && new_sl) begin
          n_sl_q <= n_sl_q + CNT_W'(1);
        end
      end
      if (cmd_i.idx_load_cnt) begin
        idx_q <= list_count_q;
      end else if (cmd_i.idx_clear) begin
        idx_q <= '0;
      end else if (cmd_i.idx_dec) begin
        idx_q <= idx_m1;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (cmd_i.step_upd) begin
        step_count_q <= step_inc;
        if (pct_en_q && over_limit) begin
          livelock_q <= 1'b1;
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_PCT_ENABLE) begin
          pct_en_q <= cfg_data_i[0];
        end else if (cfg_idx_i == CFG_STEP_LIMIT) begin
          step_limit_q <= cfg_data_i[STEP_W-1:0];
        end
      end
    end
  end

  // result staging and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      res_kind_q <= cmd_i.res_kind;
      res_pick_q <= cmd_i.res_pick_entry ? plist_rdata_q : '0;
    end
    if (cmd_i.out_load) begin
      out_kind_q <= res_kind_q;
      out_pick_q <= res_pick_q;
      out_live_q <= livelock_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign res_valid_o     = out_valid_q;
  assign res_kind_o      = out_kind_q;
  assign res_picked_id_o = out_pick_q;
  assign res_livelock_o  = out_live_q;

endmodule

// ===== hdl/pct_checker.sv =====
// port-level assertions of the priority thread picker and their bind
module pct_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [pct_pkg::KIND_W-1:0] rsp_kind_i,
  input logic [pct_pkg::TID_W-1:0]  rsp_picked_id_i,
  input logic                       rsp_livelock_i
);
  import pct_pkg::*;

  logic live_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_seen_q <= 1'b0;
    end else if (rsp_valid_i && rsp_ready_i && rsp_livelock_i) begin
      live_seen_q <= 1'b1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped before transfer");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable(rsp_kind_i) && $stable(rsp_picked_id_i) && $stable(rsp_livelock_i))
    else $error("stalled result changed");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_kind_i == K_ACK) || (rsp_kind_i == K_PICK) ||
      (rsp_kind_i == K_FALLBACK) || (rsp_kind_i == K_WAKE) ||
      (rsp_kind_i == K_NONE) || (rsp_kind_i == K_FULL))
    else $error("result kind out of range");

  a_pick_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_kind_i != K_PICK) |-> rsp_picked_id_i == '0)
    else $error("picked id set on a non-pick result");

  a_livelock_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && live_seen_q |-> rsp_livelock_i)
    else $error("livelock flag cleared");

endmodule

bind pct_priority_thread_picker pct_checker u_pct_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_kind_i      (rsp_o.kind),
  .rsp_picked_id_i (rsp_o.picked_id),
  .rsp_livelock_i  (rsp_o.livelock)
);

// ===== tb/pct_pick_checker.sv =====
// result checker for the priority thread picker: tracks scheduler state and compares results
`timescale 1ns / 100ps

module pct_pick_checker
  import pct_pkg::*;
#(
  parameter int NTHREADS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pct_req_if                    req_i,
  pct_res_if                    rsp_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           in_flight_o,
  output int unsigned           errors_o
);

  typedef struct packed {
    kind_e            kind;
    logic [TID_W-1:0] id;
    logic             livelock;
  } pick_res_t;

  status_e           thread_st [NTHREADS];
  logic [TID_W-1:0]  prio_list [NTHREADS];
  int                list_len;
  logic [STEP_W-1:0] steps;
  logic              livelock_q;
  logic              pct_on;
  logic [STEP_W-1:0] limit;
  pick_res_t         pending_picks [$];
  int unsigned       results_seen;

  function automatic pick_res_t schedule_step(input logic [OPC_W-1:0] op,
                                              input logic [TID_W-1:0] tid,
                                              input logic [STS_W-1:0] st,
                                              input logic [POS_W-1:0] pos);
    pick_res_t r;
    int        at;
    int        i;
    bit        any_en;
    bit        any_sl;
    r.kind     = K_ACK;
    r.id       = '0;
    r.livelock = 1'b0;
    any_en     = 1'b0;
    any_sl     = 1'b0;
    case (op)
      OP_ADD: begin
        if (int'(tid) < NTHREADS) begin
          if (list_len >= NTHREADS) begin
            r.kind = K_FULL;
          end else begin
            thread_st[tid] = ST_ENABLED;
            at = (int'(pos) > list_len) ? list_len : int'(pos);
            for (i = list_len; i > at; i--) prio_list[i] = prio_list[i-1];
            prio_list[at] = tid;
            list_len++;
          end
        end
      end
      OP_SET: begin
        if (int'(tid) < NTHREADS && st <= ST_SLEEPING) thread_st[tid] = status_e'(st);
      end
      OP_SELECT: begin
        for (i = 0; i < NTHREADS; i++) begin
          if (thread_st[i] == ST_ENABLED) any_en = 1'b1;
          else if (thread_st[i] == ST_SLEEPING) any_sl = 1'b1;
        end
        if (!any_en) begin
          r.kind = any_sl ? K_WAKE : K_NONE;
        end else begin
          if (steps != '1) steps++;
          if (!pct_on) begin
            r.kind = K_FALLBACK;
          end else if (steps > limit) begin
            livelock_q = 1'b1;
            r.kind     = K_FALLBACK;
          end else begin
            r.kind = K_PICK;
            for (i = 0; i < list_len; i++) begin
              if (thread_st[prio_list[i]] == ST_ENABLED) begin
                r.id = prio_list[i];
                break;
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.livelock = livelock_q;
    return r;
  endfunction

  task automatic flag_error(input string what);
    errors_o++;
    if (errors_o <= 10) $display("%0t: result %0d: %s", $time, results_seen, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pick_res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NTHREADS; i++) begin
        thread_st[i] = ST_DISABLED;
        prio_list[i] = '0;
      end
      list_len   = 0;
      steps      = '0;
      livelock_q = 1'b0;
      pct_on     = 1'b1;
      limit      = '1;
      pending_picks.delete();
      results_seen = 0;
      in_flight_o  = 0;
      errors_o     = 0;
    end else begin
      // result transfer
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_picks.size() == 0) begin
          flag_error($sformatf("unexpected result kind %0d id %0d livelock %0b",
                               rsp_i.kind, rsp_i.picked_id, rsp_i.livelock));
        end else begin
          want = pending_picks.pop_front();
          if (rsp_i.kind !== want.kind || rsp_i.picked_id !== want.id ||
              rsp_i.livelock !== want.livelock) begin
            flag_error($sformatf(
              "mismatch: expected kind %0d id %0d livelock %0b, got kind %0d id %0d livelock %0b",
              want.kind, want.id, want.livelock,
              rsp_i.kind, rsp_i.picked_id, rsp_i.livelock));
          end
        end
        results_seen++;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PCT_ENABLE: pct_on = cfg_data_i[0];
          CFG_STEP_LIMIT: limit = cfg_data_i[STEP_W-1:0];
          default: ;
        endcase
      end
      // request transfer
      if (req_i.valid && req_i.ready) begin
        pending_picks.push_back(schedule_step(req_i.opcode, req_i.thread_id,
                                              req_i.status, req_i.insert_pos));
      end
      in_flight_o = pending_picks.size();
    end
  end

endmodule

// ===== tb/pct_priority_thread_picker_test.sv =====
// testbench top for the priority thread picker: reset, stimulus, stalls and verdict
`timescale 1ns / 100ps

module pct_priority_thread_picker_test;
  import pct_pkg::*;

  localparam int NTHREADS     = 16;
  localparam int RANDOM_ITEMS = 2000;

  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [STS_W-1:0] ST_UNUSED = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  bit                    steady_tx;
  bit                    steady_rx;
  int unsigned           in_flight;
  int unsigned           errors;
  int unsigned           sent_items;
  int unsigned           selects_sent;

  pct_req_if req ();
  pct_res_if rsp ();

  pct_priority_thread_picker #(
    .MAX_THREADS(NTHREADS)
  ) dut (
    .clk_i,
    .rst_ni,
    .req_i(req),
    .rsp_o(rsp),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  pct_pick_checker #(
    .NTHREADS(NTHREADS)
  ) u_pick_check (
    .clk_i,
    .rst_ni,
    .req_i(req),
    .rsp_i(rsp),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_flight_o(in_flight),
    .errors_o(errors)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_req(input logic [OPC_W-1:0] op, input logic [TID_W-1:0] tid,
                          input logic [STS_W-1:0] st, input logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = steady_tx ? 0 : idle_cycles();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.valid      <= 1'b1;
    req.opcode     <= op;
    req.thread_id  <= tid;
    req.status     <= st;
    req.insert_pos <= pos;
    do @(posedge clk_i); while (!req.ready);
    sent_items++;
    if (op == OP_SELECT) selects_sent++;
    @(negedge clk_i);
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    while (in_flight != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin : result_drain
    int unsigned stall;
    int unsigned taken;
    stall     = 0;
    taken     = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        stall--;
      end else begin
        rsp.ready <= 1'b1;
      end
      @(posedge clk_i);
      if (rsp.valid && rsp.ready) begin
        taken++;
        if (taken == 400 || taken == 1500) stall = 150;
        else if (!steady_rx) stall = idle_cycles();
      end
    end
  end

  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned       base;
    int unsigned       pick;
    bit                all_off;
    logic [OPC_W-1:0]  op;
    logic [TID_W-1:0]  tid;
    logic [STS_W-1:0]  st;
    logic [POS_W-1:0]  pos;
    logic [STEP_W-1:0] lim;

    rst_ni         = 1'b0;
    req.valid      = 1'b0;
    req.opcode     = '0;
    req.thread_id  = '0;
    req.status     = '0;
    req.insert_pos = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    steady_tx      = 1'b0;
    steady_rx      = 1'b0;
    sent_items     = 0;
    selects_sent   = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty table, sleepers only, enabled but unlisted, unused codes
    send_req(OP_SELECT, 4'd0, ST_DISABLED, 4'd0);
    send_req(OP_SET, 4'd3, ST_SLEEPING, 4'd0);
    send_req(OP_SELECT, 4'd15, ST_UNUSED, 4'd15);
    send_req(OP_SET, 4'd5, ST_ENABLED, 4'd0);
    send_req(OP_SELECT, 4'd0, ST_DISABLED, 4'd0);
    send_req(OP_SET, 4'd5, ST_UNUSED, 4'd7);
    send_req(OP_UNUSED, 4'd15, ST_UNUSED, 4'd15);
    // inserts: past the end, at the head, duplicate, at the exact end
    send_req(OP_ADD, 4'd15, ST_DISABLED, 4'd15);
    send_req(OP_ADD, 4'd0, ST_DISABLED, 4'd0);
    send_req(OP_ADD, 4'd15, ST_SLEEPING, 4'd1);
    send_req(OP_ADD, 4'd9, ST_ENABLED, 4'd0);
    send_req(OP_ADD, 4'd12, ST_UNUSED, 4'd4);
    send_req(OP_SELECT, 4'd0, ST_DISABLED, 4'd0);
    send_req(OP_SET, 4'd9, ST_DISABLED, 4'd0);
    send_req(OP_SELECT, 4'd0, ST_DISABLED, 4'd0);
    send_req(OP_SET, 4'd0, ST_SLEEPING, 4'd0);
    send_req(OP_SELECT, 4'd0, ST_DISABLED, 4'd0);
    settle();
    write_reg(CFG_PCT_ENABLE, CFG_DATA_W'(0));
    send_req(OP_SELECT, 4'd0, ST_DISABLED, 4'd0);
    settle();
    write_reg(CFG_PCT_ENABLE, CFG_DATA_W'(1));

    base = sent_items;
    while (sent_items < base + RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 9))
        0:       lim = '0;
        1, 2:    lim = '1;
        3, 4:    lim = STEP_W'($urandom_range(0, 65535));
        default: lim = STEP_W'($urandom_range(selects_sent / 2, selects_sent + 20));
      endcase
      write_reg(CFG_STEP_LIMIT, lim);
      write_reg(CFG_PCT_ENABLE, CFG_DATA_W'($urandom_range(0, 3) != 0));
      steady_tx = ($urandom_range(0, 5) == 0);
      steady_rx = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 3) == 0) begin
        // park every thread, select, then wake a few and select again
        all_off = ($urandom_range(0, 2) == 0);
        for (int t = 0; t < NTHREADS; t++) begin
          st = (all_off || $urandom_range(0, 1) == 1) ? ST_DISABLED : ST_SLEEPING;
          send_req(OP_SET, TID_W'(t), st, POS_W'($urandom_range(0, 15)));
        end
        repeat ($urandom_range(1, 3))
          send_req(OP_SELECT, TID_W'($urandom_range(0, 15)), STS_W'($urandom_range(0, 3)),
                   POS_W'($urandom_range(0, 15)));
        repeat ($urandom_range(1, 2))
          send_req(OP_SET, TID_W'($urandom_range(0, 15)), ST_ENABLED,
                   POS_W'($urandom_range(0, 15)));
        repeat ($urandom_range(1, 4))
          send_req(OP_SELECT, TID_W'($urandom_range(0, 15)), STS_W'($urandom_range(0, 3)),
                   POS_W'($urandom_range(0, 15)));
      end else begin
        repeat ($urandom_range(20, 80)) begin
          pick = $urandom_range(0, 99);
          tid  = TID_W'($urandom_range(0, 15));
          pos  = POS_W'($urandom_range(0, 15));
          st   = STS_W'($urandom_range(0, 3));
          if (pick < 12) begin
            op = OP_ADD;
          end else if (pick < 50) begin
            op = OP_SET;
            case ($urandom_range(0, 19))
              0:                      st = ST_UNUSED;
              1, 2, 3, 4, 5, 6, 7, 8: st = ST_ENABLED;
              9, 10, 11, 12, 13, 14:  st = ST_SLEEPING;
              default:                st = ST_DISABLED;
            endcase
          end else if (pick < 95) begin
            op = OP_SELECT;
          end else begin
            op = OP_UNUSED;
          end
          send_req(op, tid, st, pos);
        end
      end
    end

    // limit boundaries after the random phase
    settle();
    steady_tx = 1'b0;
    steady_rx = 1'b0;
    write_reg(CFG_PCT_ENABLE, CFG_DATA_W'(1));
    write_reg(CFG_STEP_LIMIT, '1);
    send_req(OP_SELECT, 4'd0, ST_DISABLED, 4'd0);
    send_req(OP_SELECT, 4'd15, ST_UNUSED, 4'd15);
    send_req(OP_ADD, TID_W'($urandom_range(0, 15)), ST_DISABLED, 4'd0);
    settle();
    write_reg(CFG_STEP_LIMIT, CFG_DATA_W'(16'hfffe));
    send_req(OP_SELECT, 4'd0, ST_DISABLED, 4'd0);
    settle();
    write_reg(CFG_STEP_LIMIT, '0);
    send_req(OP_SELECT, 4'd0, ST_DISABLED, 4'd0);
    settle();

    repeat (64) @(negedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
